/* rtl/lss_pkg.sv */
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants for the searchable stack
// operation and status codes, cell control group and controller states
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int POS_W     = 5;
    localparam int STS_W     = 2;

    localparam logic [DATA_W-1:0] NO_DATA = '1;

    // request codes
    localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PEEK   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FIND   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_TOP    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_BOTTOM = 3'd5;

    // result status codes
    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_OVERFLOW = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY    = 2'd2;
    localparam logic [STS_W-1:0] STS_RANGE    = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    // push moves every cell one place down, pull one place up
    typedef struct packed {
        logic push;
        logic pull;
    } t_cell_ctrl;

endpackage

/* rtl/lss_cell.sv */
// ----------------------------------------------------------------------------
// lss_cell: one stack cell
// holds a word and its valid bit, loads from the neighbour above or below
// ----------------------------------------------------------------------------
module lss_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lss_pkg::t_cell_ctrl          i_ctrl,
    input  logic [lss_pkg::DATA_W-1:0]   i_up_data,
    input  logic                         i_up_valid,
    input  logic [lss_pkg::DATA_W-1:0]   i_dn_data,
    input  logic                         i_dn_valid,
    output logic [lss_pkg::DATA_W-1:0]   o_data,
    output logic                         o_valid
);

    logic [lss_pkg::DATA_W-1:0] r_data;
    logic                       r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_data <= i_up_data;
        end else if (i_ctrl.pull) begin
            r_data <= i_dn_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.push) begin
            r_valid <= i_up_valid;
        end else if (i_ctrl.pull) begin
            r_valid <= i_dn_valid;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

/* rtl/lifo_stack_with_search.sv */
// ----------------------------------------------------------------------------
// lifo_stack_with_search: bounded stack of 32-bit words with search
// a chain of cells, top of stack in the first cell, plus a small controller
// ----------------------------------------------------------------------------
// usage
//   request channel: i_valid / o_stall with i_func, i_value, i_position;
//   a beat is taken on a rising edge with i_valid high and o_stall low
//   result channel: o_valid / i_stall with o_data, o_found, o_status;
//   every request gives exactly one result beat, in request order
// request handling
//   push, pop, top and requests that fail at once (empty, out of range,
//   overflow, unused code): result in the cycle after the request beat, one
//   request per cycle while no held result stalls the input
//   peek, find and bottom: the chain is rotated once round all I_DEPTH
//   cells, the first cell being examined each step, and the result is
//   loaded when the turn ends; o_stall is high meanwhile
// reset
//   synchronous, active low; the stack comes up empty, no result pending
// stall
//   a result waits in the output register while i_stall is high; a new
//   request is still taken if the result is being drained in that cycle
// ----------------------------------------------------------------------------
module lifo_stack_with_search #(
    parameter int I_DEPTH = lss_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lss_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [lss_pkg::DATA_W-1:0]   i_value,
    input  logic [lss_pkg::POS_W-1:0]           i_position,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [lss_pkg::DATA_W-1:0]   o_data,
    output logic                                o_found,
    output logic [lss_pkg::STS_W-1:0]           o_status
);

    localparam int CW = $clog2(I_DEPTH + 1);        // fill count
    localparam int KW = $clog2(I_DEPTH);            // index along the chain
    localparam int PW = (CW > lss_pkg::POS_W) ? CW : lss_pkg::POS_W;

    // chain taps
    logic [lss_pkg::DATA_W-1:0] w_data [I_DEPTH];
    logic [I_DEPTH-1:0]         w_valid;
    lss_pkg::t_cell_ctrl        w_ctrl;
    logic [lss_pkg::DATA_W-1:0] w_tail_data;
    logic                       w_tail_valid;

    // controller state
    lss_pkg::t_state            r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [KW-1:0]              r_k, n_k;
    logic [KW-1:0]              r_tgt, n_tgt;
    logic [lss_pkg::FUNC_W-1:0] r_func, n_func;
    logic [lss_pkg::DATA_W-1:0] r_key, n_key;
    logic                       r_hit, n_hit;
    logic [lss_pkg::DATA_W-1:0] r_cap, n_cap;

    // output register
    logic                       r_out_valid;
    logic [lss_pkg::DATA_W-1:0] r_out_data;
    logic                       r_out_found;
    logic [lss_pkg::STS_W-1:0]  r_out_status;

    logic                       w_ld_out;
    logic [lss_pkg::DATA_W-1:0] w_res_data;
    logic                       w_res_found;
    logic [lss_pkg::STS_W-1:0]  w_res_status;

    logic                       w_acc;
    logic [lss_pkg::POS_W-1:0]  w_pos_eff;
    logic                       w_empty;
    logic                       w_full;
    logic                       w_beyond;

    // take a request only when idle and the result slot is free or draining
    assign o_stall = (r_state != lss_pkg::ST_IDLE) || (r_out_valid && i_stall);
    assign w_acc   = i_valid && !o_stall;

    // position zero reads as the top
    assign w_pos_eff = (i_position == '0) ? lss_pkg::POS_W'(1) : i_position;
    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == CW'(I_DEPTH));
    assign w_beyond  = (PW'(w_pos_eff) > PW'(r_count));

    // the last cell is fed from the first one while rotating, else empty
    assign w_tail_data  = w_data[0];
    assign w_tail_valid = (r_state == lss_pkg::ST_WALK) && w_valid[0];

    // ------------------------------------------------------------------------
    // cell chain
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < I_DEPTH; g++) begin : g_cell
        logic [lss_pkg::DATA_W-1:0] w_up_data;
        logic                       w_up_valid;
        logic [lss_pkg::DATA_W-1:0] w_dn_data;
        logic                       w_dn_valid;

        if (g == 0) begin : g_top
            assign w_up_data  = i_value;
            assign w_up_valid = 1'b1;
        end else begin : g_mid_up
            assign w_up_data  = w_data[g-1];
            assign w_up_valid = w_valid[g-1];
        end

        if (g == I_DEPTH - 1) begin : g_tail
            assign w_dn_data  = w_tail_data;
            assign w_dn_valid = w_tail_valid;
        end else begin : g_mid_dn
            assign w_dn_data  = w_data[g+1];
            assign w_dn_valid = w_valid[g+1];
        end

        lss_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_up_data  (w_up_data),
            .i_up_valid (w_up_valid),
            .i_dn_data  (w_dn_data),
            .i_dn_valid (w_dn_valid),
            .o_data     (w_data[g]),
            .o_valid    (w_valid[g])
        );
    end

    // ------------------------------------------------------------------------
    // controller: state register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lss_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_tgt  <= n_tgt;
        r_func <= n_func;
        r_key  <= n_key;
        r_hit  <= n_hit;
        r_cap  <= n_cap;
    end

    // ------------------------------------------------------------------------
    // controller: next state, chain control and result
    // ------------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_k          = r_k;
        n_tgt        = r_tgt;
        n_func       = r_func;
        n_key        = r_key;
        n_hit        = r_hit;
        n_cap        = r_cap;
        w_ctrl       = '0;
        w_ld_out     = 1'b0;
        w_res_data   = lss_pkg::NO_DATA;
        w_res_found  = 1'b0;
        w_res_status = lss_pkg::STS_OK;

        case (r_state)
            lss_pkg::ST_IDLE: begin
                n_k   = '0;
                n_hit = 1'b0;
                n_cap = lss_pkg::NO_DATA;
                n_func = i_func;
                n_key  = i_value;
                if (w_acc) begin
                    w_ld_out = 1'b1;
                    case (i_func)
                        lss_pkg::FN_PUSH: begin
                            if (w_full) begin
                                w_res_status = lss_pkg::STS_OVERFLOW;
                            end else begin
                                w_ctrl.push = 1'b1;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        lss_pkg::FN_POP: begin
                            if (w_empty) begin
                                w_res_status = lss_pkg::STS_EMPTY;
                            end else begin
                                w_ctrl.pull = 1'b1;
                                n_count     = r_count - CW'(1);
                                w_res_data  = w_data[0];
                            end
                        end
                        lss_pkg::FN_PEEK: begin
                            if (w_empty) begin
                                w_res_status = lss_pkg::STS_EMPTY;
                            end else if (w_beyond) begin
                                w_res_status = lss_pkg::STS_RANGE;
                            end else begin
                                // in range, so the target index fits the chain
                                w_ld_out = 1'b0;
                                n_tgt    = KW'(w_pos_eff - lss_pkg::POS_W'(1));
                                n_state  = lss_pkg::ST_WALK;
                            end
                        end
                        lss_pkg::FN_FIND: begin
                            if (w_empty) begin
                                w_res_status = lss_pkg::STS_EMPTY;
                            end else begin
                                w_ld_out = 1'b0;
                                n_state  = lss_pkg::ST_WALK;
                            end
                        end
                        lss_pkg::FN_TOP: begin
                            if (w_empty) begin
                                w_res_status = lss_pkg::STS_EMPTY;
                            end else begin
                                w_res_data = w_data[0];
                            end
                        end
                        lss_pkg::FN_BOTTOM: begin
                            if (w_empty) begin
                                w_res_status = lss_pkg::STS_EMPTY;
                            end else begin
                                w_ld_out = 1'b0;
                                n_tgt    = KW'(r_count - CW'(1));
                                n_state  = lss_pkg::ST_WALK;
                            end
                        end
                        default: begin
                            // unused code: fixed result, no change
                        end
                    endcase
                end
            end
            lss_pkg::ST_WALK: begin
                // first cell holds the entry r_k places below the top
                w_ctrl.pull = 1'b1;
                if (r_func == lss_pkg::FN_FIND) begin
                    if (w_valid[0] && (w_data[0] == r_key)) begin
                        n_hit = 1'b1;
                    end
                end else if (r_k == r_tgt) begin
                    n_cap = w_data[0];
                end
                n_k = r_k + KW'(1);
                if (r_k == KW'(I_DEPTH - 1)) begin
                    // full turn done, chain back in its original order
                    w_ld_out    = 1'b1;
                    w_res_found = n_hit;
                    w_res_data  = (r_func == lss_pkg::FN_FIND) ? lss_pkg::NO_DATA : n_cap;
                    n_state     = lss_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lss_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ld_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_out_data   <= w_res_data;
            r_out_found  <= w_res_found;
            r_out_status <= w_res_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;
    assign o_found  = r_out_found;
    assign o_status = r_out_status;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
`ifndef ASSERT_OFF
    // fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(I_DEPTH))
        else $error("fill count beyond depth");

    // between requests the occupied cells match the fill count
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lss_pkg::ST_IDLE) |-> ($countones(w_valid) == int'(r_count)))
        else $error("cell valid bits disagree with fill count");

    // a pop on a non-empty stack takes exactly one word
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_func == lss_pkg::FN_POP) && (r_count != '0))
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not lower fill count");

    // a rotation never overwrites an undelivered result before it ends
    a_walk_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == lss_pkg::ST_WALK) |-> !r_out_valid)
        else $error("result slot busy at start of rotation");
`endif

endmodule

/* verif/lifo_stack_with_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_search_tb: self-checking bench for the searchable stack
// a short table of directed requests, then biased random fill and drain
// bursts; each result beat is checked against a hand-typed reply or a shadow
// stack kept in the bench
module lifo_stack_with_search_tb;

    localparam int STACK_SLOTS     = lss_pkg::DEPTH_DEF;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_PER_RUN  = 300;

    // codes the block leaves unused: no state change, plain reply
    localparam logic [lss_pkg::FUNC_W-1:0] FN_SPARE_LO = lss_pkg::FN_BOTTOM + 1'b1;
    localparam logic [lss_pkg::FUNC_W-1:0] FN_SPARE_HI = '1;

    // deepest legal peek on a full stack, and one past it
    localparam logic [lss_pkg::POS_W-1:0] POS_LAST = STACK_SLOTS[lss_pkg::POS_W-1:0];
    localparam logic [lss_pkg::POS_W-1:0] POS_PAST = POS_LAST + 1'b1;

    typedef struct {
        logic [lss_pkg::FUNC_W-1:0]        func;
        logic signed [lss_pkg::DATA_W-1:0] value;
        logic [lss_pkg::POS_W-1:0]         position;
    } t_request;

    typedef struct {
        logic signed [lss_pkg::DATA_W-1:0] data;
        logic                              found;
        logic [lss_pkg::STS_W-1:0]         status;
    } t_reply;

    // one row of the directed table; known rows carry a hand-typed reply
    typedef struct {
        t_request rq;
        bit       known;
        t_reply   rp;
    } t_row;

    logic                              i_clk      = 1'b0;
    logic                              i_rst_n    = 1'b0;
    logic                              i_valid    = 1'b0;
    logic [lss_pkg::FUNC_W-1:0]        i_func     = lss_pkg::FN_PUSH;
    logic signed [lss_pkg::DATA_W-1:0] i_value    = '0;
    logic [lss_pkg::POS_W-1:0]         i_position = '0;
    logic                              i_stall    = 1'b0;
    logic                              o_stall;
    logic                              o_valid;
    logic signed [lss_pkg::DATA_W-1:0] o_data;
    logic                              o_found;
    logic [lss_pkg::STS_W-1:0]         o_status;

    // shadow copy of the stack, entry 0 is the bottom
    logic signed [lss_pkg::DATA_W-1:0] lifo_words [STACK_SLOTS];
    int                                lifo_fill = 0;

    t_reply                            reply_queue [$];
    t_row                              directed_rows [$];
    logic signed [lss_pkg::DATA_W-1:0] key_pool [8];
    int                                mismatch_count = 0;
    int unsigned                       send_idle_pct  = 38;
    int unsigned                       recv_idle_pct  = 73;
    logic                              hold_off_req   = 1'b0;

    always #1 i_clk = ~i_clk;

    lifo_stack_with_search dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_func     (i_func),
        .i_value    (i_value),
        .i_position (i_position),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .o_found    (o_found),
        .o_status   (o_status)
    );

    // apply one request to the shadow stack and work out its reply
    function automatic t_reply lifo_apply(t_request rq);
        t_reply rp;
        int     slot;
        rp.data   = lss_pkg::NO_DATA;
        rp.found  = 1'b0;
        rp.status = lss_pkg::STS_OK;
        // position zero reads the top, same as position one
        slot = (rq.position == '0) ? 1 : int'(rq.position);
        case (rq.func)
            lss_pkg::FN_PUSH: begin
                if (lifo_fill >= STACK_SLOTS) begin
                    rp.status = lss_pkg::STS_OVERFLOW;
                end else begin
                    lifo_words[lifo_fill] = rq.value;
                    lifo_fill++;
                end
            end
            lss_pkg::FN_POP: begin
                if (lifo_fill == 0) begin
                    rp.status = lss_pkg::STS_EMPTY;
                end else begin
                    lifo_fill--;
                    rp.data = lifo_words[lifo_fill];
                end
            end
            lss_pkg::FN_PEEK: begin
                if (lifo_fill == 0) begin
                    rp.status = lss_pkg::STS_EMPTY;
                end else if (slot > lifo_fill) begin
                    rp.status = lss_pkg::STS_RANGE;
                end else begin
                    rp.data = lifo_words[lifo_fill - slot];
                end
            end
            lss_pkg::FN_FIND: begin
                if (lifo_fill == 0) begin
                    rp.status = lss_pkg::STS_EMPTY;
                end else begin
                    for (int k = 0; k < lifo_fill; k++) begin
                        if (lifo_words[k] == rq.value) begin
                            rp.found = 1'b1;
                        end
                    end
                end
            end
            lss_pkg::FN_TOP: begin
                if (lifo_fill == 0) begin
                    rp.status = lss_pkg::STS_EMPTY;
                end else begin
                    rp.data = lifo_words[lifo_fill - 1];
                end
            end
            lss_pkg::FN_BOTTOM: begin
                if (lifo_fill == 0) begin
                    rp.status = lss_pkg::STS_EMPTY;
                end else begin
                    rp.data = lifo_words[0];
                end
            end
            default: begin
            end
        endcase
        return rp;
    endfunction

    // half the words come from a small pool so that find sees real hits
    function automatic logic signed [lss_pkg::DATA_W-1:0] pick_word();
        if ($urandom_range(1) == 0) begin
            return key_pool[$urandom_range(7)];
        end
        return $urandom;
    endfunction

    // filling bursts lean on push, draining bursts on pop
    function automatic t_request random_request(bit filling);
        t_request    rq;
        int unsigned sel;
        int unsigned push_cut;
        int unsigned pick;
        sel         = $urandom_range(99);
        push_cut    = filling ? 50 : 15;
        rq.value    = pick_word();
        // mostly around the current depth, sometimes anywhere in the field
        if ($urandom_range(9) < 7) begin
            pick = $urandom_range(lifo_fill + 1);
        end else begin
            pick = $urandom_range(31);
        end
        rq.position = pick[lss_pkg::POS_W-1:0];
        if (sel < push_cut) begin
            rq.func = lss_pkg::FN_PUSH;
        end else if (sel < 60) begin
            rq.func = lss_pkg::FN_POP;
        end else if (sel < 72) begin
            rq.func = lss_pkg::FN_PEEK;
        end else if (sel < 84) begin
            rq.func = lss_pkg::FN_FIND;
        end else if (sel < 90) begin
            rq.func = lss_pkg::FN_TOP;
        end else if (sel < 96) begin
            rq.func = lss_pkg::FN_BOTTOM;
        end else begin
            pick    = $urandom_range(FN_SPARE_HI, FN_SPARE_LO);
            rq.func = pick[lss_pkg::FUNC_W-1:0];
        end
        return rq;
    endfunction

    task automatic add_plain(input logic [lss_pkg::FUNC_W-1:0] func,
                             input logic signed [lss_pkg::DATA_W-1:0] value,
                             input logic [lss_pkg::POS_W-1:0] position);
        t_row row;
        row.rq.func     = func;
        row.rq.value    = value;
        row.rq.position = position;
        row.known       = 1'b0;
        row.rp.data     = lss_pkg::NO_DATA;
        row.rp.found    = 1'b0;
        row.rp.status   = lss_pkg::STS_OK;
        directed_rows.push_back(row);
    endtask

    task automatic add_known(input logic [lss_pkg::FUNC_W-1:0] func,
                             input logic signed [lss_pkg::DATA_W-1:0] value,
                             input logic [lss_pkg::POS_W-1:0] position,
                             input logic [lss_pkg::STS_W-1:0] status);
        add_plain(func, value, position);
        directed_rows[$].known     = 1'b1;
        directed_rows[$].rp.status = status;
    endtask

    // offer one request beat, hold it until taken, then log its reply
    task automatic offer_beat(input t_request rq, input bit known, input t_reply typed);
        t_reply predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= rq.func;
        i_value    <= rq.value;
        i_position <= rq.position;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        // shadow stack always advances, even where the reply is hand-typed
        predicted = lifo_apply(rq);
        reply_queue.push_back(known ? typed : predicted);
    endtask

    // result side: random stall, plus one long hold-off on request
    initial begin : result_sink
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !held) begin
                // keep the output blocked so the block backs up onto its input
                held    = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // every taken result beat against the oldest reply still owed
    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reply_queue.size() == 0) begin
                $error("result beat with nothing owed: data %0d found %0b status %0d",
                       o_data, o_found, o_status);
                mismatch_count++;
            end else begin
                want = reply_queue.pop_front();
                if (o_data !== want.data) begin
                    $error("data: expected %0d, got %0d", want.data, o_data);
                    mismatch_count++;
                end
                if (o_found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, o_found);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_request rq;
        t_reply   none;
        int       run_left;
        bit       filling;
        none.data   = lss_pkg::NO_DATA;
        none.found  = 1'b0;
        none.status = lss_pkg::STS_OK;
        run_left    = 0;
        filling     = 1'b0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 32'sh8000_0000;
        key_pool[3] = 32'sh7fff_ffff;
        key_pool[4] = 32'sd1;
        for (int k = 5; k < 8; k++) begin
            key_pool[k] = $urandom;
        end

        // empty stack: every read fails, unused code still answers plainly
        add_known(lss_pkg::FN_POP, '0, '0, lss_pkg::STS_EMPTY);
        add_known(lss_pkg::FN_PEEK, '0, '0, lss_pkg::STS_EMPTY);
        add_known(lss_pkg::FN_FIND, '0, '0, lss_pkg::STS_EMPTY);
        add_known(lss_pkg::FN_TOP, '0, '0, lss_pkg::STS_EMPTY);
        add_known(lss_pkg::FN_BOTTOM, '0, '0, lss_pkg::STS_EMPTY);
        add_known(FN_SPARE_LO, '1, '1, lss_pkg::STS_OK);
        // most negative word at the bottom, most positive above it
        add_known(lss_pkg::FN_PUSH, 32'sh8000_0000, '0, lss_pkg::STS_OK);
        add_known(lss_pkg::FN_PUSH, 32'sh7fff_ffff, '0, lss_pkg::STS_OK);
        for (int k = 0; k < STACK_SLOTS - 2; k++) begin
            add_known(lss_pkg::FN_PUSH, (k == 0) ? '0 : (k == 1) ? '1 : $urandom, '0,
                      lss_pkg::STS_OK);
        end
        // full: push is dropped
        add_known(lss_pkg::FN_PUSH, 32'sh5a5a_a5a5, '1, lss_pkg::STS_OVERFLOW);
        add_plain(lss_pkg::FN_PEEK, '0, '0);
        add_plain(lss_pkg::FN_PEEK, '0, POS_LAST);
        add_known(lss_pkg::FN_PEEK, '0, POS_PAST, lss_pkg::STS_RANGE);
        add_plain(lss_pkg::FN_FIND, 32'sh7fff_ffff, '0);
        add_plain(lss_pkg::FN_BOTTOM, '0, '0);
        add_plain(lss_pkg::FN_POP, '0, '0);
        add_known(FN_SPARE_HI, '0, '0, lss_pkg::STS_OK);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            offer_beat(directed_rows[k].rq, directed_rows[k].known, directed_rows[k].rp);
        end

        // three runs: receiver idles more, then sender, then neither
        for (int run = 0; run < 3; run++) begin
            send_idle_pct = (run == 0) ? 38 : (run == 1) ? 73 : 0;
            recv_idle_pct = (run == 0) ? 73 : (run == 1) ? 38 : 0;
            if (run == 2) begin
                hold_off_req <= 1'b1;
            end
            repeat (RANDOM_PER_RUN) begin
                if (run_left == 0) begin
                    filling  = !filling;
                    run_left = $urandom_range(30, 10);
                end
                run_left--;
                rq = random_request(filling);
                offer_beat(rq, 1'b0, none);
            end
        end
        i_valid <= 1'b0;

        // drain, then leave room for a stray late beat to show up
        while (reply_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * STACK_SLOTS + 8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #(1_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
